### sv/modbus_rtu_master_framer_assert.svh
// Assertion macros shared by the Modbus RTU master framer.
`ifndef MODBUS_RTU_MASTER_FRAMER_ASSERT_SVH
`define MODBUS_RTU_MASTER_FRAMER_ASSERT_SVH

// Implication checked at every edge outside reset.
`define MBRTU_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer implication check failed");

// Next-cycle implication checked at every edge, reset included.
`define MBRTU_ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("framer next-cycle check failed");

`endif

### sv/mbrtu_pkg.sv
// Types, codes and constants shared by the Modbus RTU master framer.
package mbrtu_pkg;

  localparam int RX_BUFFER_BYTES_DEF = 64;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_COIL  = 2'd1;
  localparam logic [1:0] CMD_REPLY = 2'd2;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_SLAVE = 2'd2;
  localparam logic [1:0] ST_FUNC  = 2'd3;

  localparam logic [7:0]  FN_READ      = 8'h03;
  localparam logic [7:0]  FN_COIL      = 8'h05;
  localparam logic [7:0]  COIL_ON_HIGH = 8'hFF;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  slave_addr;
    logic [15:0] start_address;
    logic [15:0] reg_count;
    logic        coil_on;
    logic [7:0]  rx_byte;
    logic        rx_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  tx_byte;
    logic [15:0] reg_word;
    logic [5:0]  reg_index;
    logic [1:0]  status;
    logic [6:0]  reg_total;
    logic        last;
  } out_item_t;

  // One unit of work handed from the parser to the sequencer.
  typedef struct packed {
    logic            is_frame;
    logic [5:0][7:0] frame;
    logic            word_valid;
    logic [15:0]     reg_word;
    logic [5:0]      reg_index;
    logic            status_valid;
    logic [1:0]      status;
    logic [6:0]      reg_total;
  } job_t;

endpackage

### sv/modbus_rtu_master_framer.sv
// Top level of the Modbus RTU master framer: request framing and reply parsing.
//
// The in_ channel takes one command per transfer: a read-holding-registers request,
// a write-single-coil request, or one byte of a slave's reply. The out_ channel gives
// result transfers: transmit bytes, register words and a reply status, with last set
// on the final result that one command causes.
// A request yields eight transmit bytes, one per cycle while out_stall is low, the
// CRC being folded in one byte per cycle as the header bytes leave. A reply byte
// yields zero, one or two results. The first result passes through the queue, the
// sequencer's job register and then the output register.
// The parser in front handles one command per cycle and hands finished jobs to a
// two-entry queue, so it keeps accepting while the sequencer is busy; in_stall rises
// only when that queue is full.
// When the receiver holds out_stall, the output register keeps its transfer, the
// sequencer pauses and, once the queue fills, in_stall is raised.
// Reset clears the expected slave and word count, the reply parser, the queue and
// the output valid; the block accepts a command in the first cycle after reset.
module modbus_rtu_master_framer #(
  parameter int RX_BUFFER_BYTES = mbrtu_pkg::RX_BUFFER_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  mbrtu_pkg::in_item_t  in_data,
  output logic                 in_stall,
  output logic                 out_valid,
  output mbrtu_pkg::out_item_t out_data,
  input  logic                 out_stall
);
  import mbrtu_pkg::*;

  `include "modbus_rtu_master_framer_assert.svh"

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_empty;
  job_t q_job;
  job_t q_head;

  // Parser: builds the request header bytes or folds a reply byte into its state.
  mbrtu_front #(
    .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  // Decoupling queue, so that the parser waits on a frame in flight only when the queue is full.
  mbrtu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Sequencer: emits the jobs one result transfer per cycle while out_stall is low.
  mbrtu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  // A status always closes the results of its reply byte.
  `MBRTU_ASSERT_IMPLY(a_status_last, clk, rst_n, out_valid && out_data.out_kind == KIND_STATUS, out_data.last)

  // Fields that do not belong to a result kind read as zero.
  `MBRTU_ASSERT_IMPLY(a_tx_only, clk, rst_n, out_valid && out_data.out_kind != KIND_TX, out_data.tx_byte == 8'h00)

  `MBRTU_ASSERT_IMPLY(a_word_clean, clk, rst_n, out_valid && out_data.out_kind == KIND_WORD, out_data.status == ST_OK && out_data.reg_total == 7'd0)

  // Coming out of a reset cycle, nothing is shown and the queue is empty.
  `MBRTU_ASSERT_NEXT(a_reset_clean, clk, !rst_n, !out_valid && !in_stall)

endmodule

### sv/mbrtu_front.sv
// Front end: accepts commands, builds request headers and parses reply bytes.
module mbrtu_front #(
  parameter int RX_BUFFER_BYTES = mbrtu_pkg::RX_BUFFER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  mbrtu_pkg::in_item_t in_data,
  output logic               in_stall,
  input  logic               q_full,
  output logic               q_push,
  output mbrtu_pkg::job_t    q_job
);
  import mbrtu_pkg::*;

  localparam int POS_W = $clog2(RX_BUFFER_BYTES + 1);
  localparam int IDX_W = POS_W - 1;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(RX_BUFFER_BYTES);

  logic [7:0]       exp_slave_r, exp_slave_nxt;
  logic [15:0]      exp_words_r, exp_words_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       decl_r, decl_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [1:0]       fault_r, fault_nxt;

  logic             accept;
  logic [POS_W-1:0] pos_after;
  logic [IDX_W-1:0] idx;
  logic [15:0]      idx16;
  logic [1:0]       st;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign idx      = IDX_W'((pos_r - POS_W'(4)) >> 1);
  assign idx16    = 16'(idx);

  always_comb begin
    exp_slave_nxt = exp_slave_r;
    exp_words_nxt = exp_words_r;
    pos_nxt       = pos_r;
    decl_nxt      = decl_r;
    pend_nxt      = pend_r;
    fault_nxt     = fault_r;
    pos_after     = pos_r;
    st            = ST_OK;
    q_push        = 1'b0;
    q_job         = '0;

    if (accept && (in_data.command == CMD_READ || in_data.command == CMD_COIL)) begin
      q_push          = 1'b1;
      q_job.is_frame  = 1'b1;
      q_job.frame[0]  = in_data.slave_addr;
      q_job.frame[2]  = in_data.start_address[15:8];
      q_job.frame[3]  = in_data.start_address[7:0];
      if (in_data.command == CMD_READ) begin
        q_job.frame[1] = FN_READ;
        q_job.frame[4] = in_data.reg_count[15:8];
        q_job.frame[5] = in_data.reg_count[7:0];
        exp_slave_nxt  = in_data.slave_addr;
        exp_words_nxt  = in_data.reg_count;
        pos_nxt        = '0;
        decl_nxt       = '0;
        pend_nxt       = '0;
        fault_nxt      = ST_OK;
      end else begin
        q_job.frame[1] = FN_COIL;
        q_job.frame[4] = in_data.coil_on ? COIL_ON_HIGH : 8'h00;
        q_job.frame[5] = 8'h00;
      end
    end else if (accept && in_data.command == CMD_REPLY) begin
      if (pos_r < POS_LIMIT) begin
        pos_after = pos_r + POS_W'(1);
        if (pos_r == POS_W'(0)) begin
          if (in_data.rx_byte != exp_slave_r) fault_nxt = ST_SLAVE;
        end else if (pos_r == POS_W'(1)) begin
          if (fault_r == ST_OK && in_data.rx_byte != FN_READ) fault_nxt = ST_FUNC;
        end else if (pos_r == POS_W'(2)) begin
          decl_nxt = in_data.rx_byte;
        end else if (pos_r[0]) begin
          pend_nxt = in_data.rx_byte;
        end else if (fault_r == ST_OK && idx16 < 16'(decl_r[7:1]) &&
                     idx16 < exp_words_r) begin
          q_job.word_valid = 1'b1;
          q_job.reg_word   = {pend_r, in_data.rx_byte};
          q_job.reg_index  = idx16[5:0];
        end
      end
      pos_nxt = pos_after;
      if (in_data.rx_last) begin
        st                 = (pos_after < POS_W'(5)) ? ST_SHORT : fault_nxt;
        q_job.status_valid = 1'b1;
        q_job.status       = st;
        q_job.reg_total    = (st == ST_OK) ? decl_nxt[7:1] : 7'd0;
        pos_nxt            = '0;
        decl_nxt           = '0;
        pend_nxt           = '0;
        fault_nxt          = ST_OK;
      end
      q_push = q_job.word_valid || q_job.status_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_slave_r <= '0;
      exp_words_r <= '0;
      pos_r       <= '0;
      decl_r      <= '0;
      pend_r      <= '0;
      fault_r     <= ST_OK;
    end else begin
      exp_slave_r <= exp_slave_nxt;
      exp_words_r <= exp_words_nxt;
      pos_r       <= pos_nxt;
      decl_r      <= decl_nxt;
      pend_r      <= pend_nxt;
      fault_r     <= fault_nxt;
    end
  end

endmodule

### sv/mbrtu_queue.sv
// Short job queue between the front end and the output sequencer.
module mbrtu_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mbrtu_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output mbrtu_pkg::job_t head
);
  import mbrtu_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### sv/mbrtu_back.sv
// Back end: walks each job out as result transfers and runs the frame CRC.
module mbrtu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  mbrtu_pkg::job_t      q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  output mbrtu_pkg::out_item_t out_data,
  input  logic                 out_stall
);
  import mbrtu_pkg::*;

  // One byte of the reflected CRC-16, one bit per step.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  job_t        job_r, job_nxt;
  logic        busy_r, busy_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   od_r, od_nxt;

  logic        load;
  logic        done;
  logic        free;
  logic [7:0]  fbyte;
  out_item_t   res;

  assign load      = !ov_r || !out_stall;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    case (step_r)
      3'd0:    fbyte = job_r.frame[0];
      3'd1:    fbyte = job_r.frame[1];
      3'd2:    fbyte = job_r.frame[2];
      3'd3:    fbyte = job_r.frame[3];
      3'd4:    fbyte = job_r.frame[4];
      3'd5:    fbyte = job_r.frame[5];
      3'd6:    fbyte = crc_r[7:0];
      default: fbyte = crc_r[15:8];
    endcase
  end

  always_comb begin
    res      = '0;
    done     = 1'b0;
    step_nxt = step_r;
    crc_nxt  = crc_r;
    if (job_r.is_frame) begin
      res.out_kind = KIND_TX;
      res.tx_byte  = fbyte;
      res.last     = (step_r == 3'd7);
      done         = (step_r == 3'd7);
      if (step_r < 3'd6) crc_nxt = crc_byte(crc_r, fbyte);
      step_nxt = step_r + 3'd1;
    end else if (step_r == 3'd0 && job_r.word_valid) begin
      res.out_kind  = KIND_WORD;
      res.reg_word  = job_r.reg_word;
      res.reg_index = job_r.reg_index;
      res.last      = !job_r.status_valid;
      done          = !job_r.status_valid;
      step_nxt      = 3'd1;
    end else begin
      res.out_kind  = KIND_STATUS;
      res.status    = job_r.status;
      res.reg_total = job_r.reg_total;
      res.last      = 1'b1;
      done          = 1'b1;
    end
  end

  always_comb begin
    free    = !busy_r || (load && done);
    q_pop   = free && !q_empty;
    job_nxt = job_r;
    busy_nxt = busy_r;
    ov_nxt  = ov_r;
    od_nxt  = od_r;
    if (load) begin
      ov_nxt = busy_r;
      od_nxt = res;
    end
    if (free) begin
      busy_nxt = !q_empty;
      job_nxt  = q_head;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    od_r  <= od_nxt;
    if (free) begin
      step_r <= 3'd0;
      crc_r  <= CRC_INIT;
    end else if (busy_r && load) begin
      step_r <= step_nxt;
      crc_r  <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

endmodule
